// ===== hdl/tmg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared constants, types, sine table and fixed-point helpers of the torus
// mesh generator.
// ----------------------------------------------------------------------------
package tmg_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SINE_TABLE_SIZE = 1024;
    localparam int TAB_BITS        = $clog2(SINE_TABLE_SIZE);
    localparam int QUARTER         = SINE_TABLE_SIZE / 4;
    localparam int TRIG_W          = FRAC_BITS + 2;

    localparam int ANG_BITS = 8 + TAB_BITS;
    localparam int TEX_BITS = FRAC_BITS + 9;
    localparam int DIV_K    = (ANG_BITS > TEX_BITS) ? ANG_BITS : TEX_BITS;
    localparam int RECIP_W  = DIV_K + 1;
    localparam int BIT_W    = $clog2(DIV_K + 1);
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'((64'd1 << DIV_K) / 64'd16);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [17:0] TEX_U_MAX = 18'h3FFFF;
    localparam logic [16:0] TEX_V_MAX = 17'h1FFFF;

    localparam logic [23:0] INNER_RESET = 24'd65536;
    localparam logic [23:0] OUTER_RESET = 24'd16384;
    localparam logic [7:0]  TESS_RESET  = 8'd16;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TESS  = 2'd2;

    localparam logic [63:0] POLY_A  = 64'd1686629713;
    localparam logic [63:0] POLY_B  = 64'd693598668;
    localparam logic [63:0] POLY_C  = 64'd85569306;
    localparam logic [63:0] POLY_D  = 64'd4858527;

    typedef logic [FRAC_BITS:0] quarter_tab_t [0:QUARTER];

    typedef struct packed {
        logic [23:0]         inner;
        logic [23:0]         outer;
        logic [7:0]          n;
        logic [RECIP_W-1:0]  recip;
        logic                busy;
    } cfg_state_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_t;
        logic signed [TRIG_W-1:0] cos_t;
        logic signed [TRIG_W-1:0] sin_p;
        logic signed [TRIG_W-1:0] cos_p;
        logic [17:0]              tex_u;
        logic [16:0]              tex_v;
        logic                     tris;
        logic [15:0]              base;
        logic [7:0]               n;
    } point_item_t;

    function automatic quarter_tab_t build_quarter();
        quarter_tab_t tab;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] s;
        for (int j = 0; j <= QUARTER; j++) begin
            z  = 64'(j) << (32 - TAB_BITS);
            z2 = (z * z) >> 30;
            t  = POLY_D;
            t  = POLY_C - ((z2 * t) >> 30);
            t  = POLY_B - ((z2 * t) >> 30);
            t  = POLY_A - ((z2 * t) >> 30);
            s  = (z * t) >> 30;
            s  = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            if (s > (64'd1 << FRAC_BITS))
                s = 64'd1 << FRAC_BITS;
            tab[j] = s[FRAC_BITS:0];
        end
        return tab;
    endfunction

    localparam quarter_tab_t SIN_QUARTER = build_quarter();

    function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [TAB_BITS-1:0] k);
        logic [1:0]          quad;
        logic [TAB_BITS-2:0] m;
        logic [TAB_BITS-2:0] j;
        logic [FRAC_BITS:0]  mag;
        quad = k[TAB_BITS-1 -: 2];
        m    = {1'b0, k[TAB_BITS-3:0]};
        j    = quad[0] ? ((TAB_BITS-1)'(QUARTER) - m) : m;
        mag  = SIN_QUARTER[j];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic signed [TRIG_W-1:0] cos_lookup(input logic [TAB_BITS-1:0] k);
        return sin_lookup(TAB_BITS'(k + TAB_BITS'(QUARTER)));
    endfunction

    // sign-magnitude product, rounded half away from zero
    function automatic logic signed [31:0] mul_round(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic [31:0] m;
        neg = a[31] ^ b[31];
        ma  = a[31] ? 32'(-a) : 32'(a);
        mb  = b[31] ? 32'(-b) : 32'(b);
        p   = (64'(ma) * 64'(mb) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        m   = p[31:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== hdl/tmg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_if
// Valid/ready channels of the torus mesh generator: grid points in, mesh
// records out, register writes.
// ----------------------------------------------------------------------------
interface tmg_grid_if;
    logic       valid;
    logic       ready;
    logic [7:0] ring_index;
    logic [7:0] col_index;

    modport source (output valid, ring_index, col_index, input ready);
    modport sink   (input valid, ring_index, col_index, output ready);
endinterface

interface tmg_mesh_if;
    logic               valid;
    logic               ready;
    logic               is_triangle;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [17:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic signed [17:0] normal_z;
    logic               last;

    modport source (output valid, is_triangle, coord_x, coord_y, coord_z, tex_u, tex_v,
                    normal_x, normal_y, normal_z, last, input ready);
    modport sink   (input valid, is_triangle, coord_x, coord_y, coord_z, tex_u, tex_v,
                    normal_x, normal_y, normal_z, last, output ready);
endinterface

interface tmg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tmg_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_cfg
// Register file; derives floor(2^K / N) bit-serially after a tess_count write.
// ----------------------------------------------------------------------------
module tmg_cfg (
    input  logic               clk,
    input  logic               rst_n,
    tmg_cfg_if.sink            cfg,
    output tmg_pkg::cfg_state_t cfg_state
);
    import tmg_pkg::*;

    logic [23:0]        inner_reg;
    logic [23:0]        outer_reg;
    logic [7:0]         n_reg;
    logic [RECIP_W-1:0] recip_reg;
    logic               busy_reg;
    logic [7:0]         rem_reg;
    logic [BIT_W-1:0]   bit_reg;

    logic               wr;
    logic [8:0]         r2;
    logic               ge;
    logic [7:0]         rem_next;
    logic [RECIP_W-1:0] recip_next;
    logic [7:0]         n_next;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_comb
    begin
        r2         = {rem_reg, bit_reg == BIT_W'(DIV_K)};
        ge         = r2 >= {1'b0, n_reg};
        rem_next   = ge ? 8'(r2 - {1'b0, n_reg}) : r2[7:0];
        recip_next = {recip_reg[RECIP_W-2:0], ge};
        n_next     = (cfg.data[7:0] == 8'd0) ? 8'd1 : cfg.data[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= INNER_RESET;
            outer_reg <= OUTER_RESET;
            n_reg     <= TESS_RESET;
            recip_reg <= RECIP_RESET;
            busy_reg  <= 1'b0;
            rem_reg   <= 8'd0;
            bit_reg   <= '0;
        end
        else
        begin
            if (busy_reg)
            begin
                rem_reg   <= rem_next;
                recip_reg <= recip_next;
                if (bit_reg == '0)
                    busy_reg <= 1'b0;
                else
                    bit_reg <= bit_reg - 1'b1;
            end
            if (wr)
            begin
                unique case (cfg.index)
                    REG_INNER: inner_reg <= cfg.data;
                    REG_OUTER: outer_reg <= cfg.data;
                    REG_TESS:
                    begin
                        n_reg     <= n_next;
                        busy_reg  <= 1'b1;
                        rem_reg   <= 8'd0;
                        recip_reg <= '0;
                        bit_reg   <= BIT_W'(DIV_K);
                    end
                    default: ;
                endcase
            end
        end
    end

    assign cfg_state.inner = inner_reg;
    assign cfg_state.outer = outer_reg;
    assign cfg_state.n     = n_reg;
    assign cfg_state.recip = recip_reg;
    assign cfg_state.busy  = busy_reg;

endmodule

// ===== hdl/tmg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_front
// Accepts grid points, divides by N through the reciprocal, looks up the
// angles and classifies the point as boundary or triangle-pair corner.
// ----------------------------------------------------------------------------
module tmg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    tmg_grid_if.sink             grid,
    input  tmg_pkg::cfg_state_t  cfg_state,
    output tmg_pkg::point_item_t item,
    output logic                 item_valid,
    input  logic                 item_ready
);
    import tmg_pkg::*;

    localparam int PROD_W = DIV_K + RECIP_W;
    localparam int QN_W   = RECIP_W + 8;
    localparam int LANES  = 4;

    function automatic logic [DIV_K-1:0] dividend(input int lane, input logic [7:0] ring,
                                                 input logic [7:0] col, input logic [7:0] n);
        logic [DIV_K-1:0] half;
        logic [DIV_K-1:0] x;
        half = DIV_K'(n >> 1);
        case (lane)
            0:       x = (DIV_K'(ring) << TAB_BITS) + half;
            1:       x = (DIV_K'(col) << TAB_BITS) + half;
            2:       x = (DIV_K'(ring) << (FRAC_BITS + 1)) + half;
            default: x = (DIV_K'(col) << FRAC_BITS) + half;
        endcase
        return x;
    endfunction

    logic                v0_reg;
    logic [7:0]          ring0_reg;
    logic [7:0]          col0_reg;
    logic                v1_reg;
    logic [7:0]          ring1_reg;
    logic [7:0]          col1_reg;
    logic [PROD_W-1:0]   prod1_reg [LANES];
    logic                v2_reg;
    logic [TAB_BITS-1:0] kt2_reg;
    logic [TAB_BITS-1:0] kp2_reg;
    logic [17:0]         u2_reg;
    logic [16:0]         v2tex_reg;
    logic                tris2_reg;
    logic [15:0]         base2_reg;

    logic                rdy0;
    logic                rdy1;
    logic                rdy2;
    logic [PROD_W-1:0]   prod_next [LANES];
    logic [RECIP_W-1:0]  quo [LANES];
    logic [7:0]          n;

    assign n          = cfg_state.n;
    assign rdy2       = !v2_reg || item_ready;
    assign rdy1       = !v1_reg || rdy2;
    assign rdy0       = !v0_reg || rdy1;
    assign grid.ready = rdy0 && !cfg_state.busy;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            logic [RECIP_W-1:0] q_est;
            logic [QN_W-1:0]    rem;
            prod_next[i] = PROD_W'(dividend(i, ring0_reg, col0_reg, n)) * PROD_W'(cfg_state.recip);
            q_est        = prod1_reg[i][PROD_W-1:DIV_K];
            rem          = QN_W'(dividend(i, ring1_reg, col1_reg, n)) - QN_W'(q_est) * QN_W'(n);
            quo[i]       = (rem >= QN_W'(n)) ? RECIP_W'(q_est + 1'b1) : q_est;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= grid.valid && !cfg_state.busy;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            ring0_reg <= grid.ring_index;
            col0_reg  <= grid.col_index;
        end
        if (rdy1)
        begin
            ring1_reg <= ring0_reg;
            col1_reg  <= col0_reg;
            for (int i = 0; i < LANES; i++)
                prod1_reg[i] <= prod_next[i];
        end
        if (rdy2)
        begin
            kt2_reg   <= quo[0][TAB_BITS-1:0];
            kp2_reg   <= quo[1][TAB_BITS-1:0];
            u2_reg    <= (quo[2] > RECIP_W'(TEX_U_MAX)) ? TEX_U_MAX : quo[2][17:0];
            v2tex_reg <= (quo[3] > RECIP_W'(TEX_V_MAX)) ? TEX_V_MAX : quo[3][16:0];
            tris2_reg <= (ring1_reg < n) && (col1_reg < n);
            base2_reg <= 16'(17'(ring1_reg) * 17'({1'b0, n} + 9'd1) + 17'(col1_reg));
        end
    end

    always_comb
    begin
        item.sin_t = sin_lookup(kt2_reg);
        item.cos_t = cos_lookup(kt2_reg);
        item.sin_p = sin_lookup(kp2_reg);
        item.cos_p = cos_lookup(kp2_reg);
        item.tex_u = u2_reg;
        item.tex_v = v2tex_reg;
        item.tris  = tris2_reg;
        item.base  = base2_reg;
        item.n     = n;
    end

    assign item_valid = v2_reg;

endmodule

// ===== hdl/tmg_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_fifo
// Short queue of classified points between front and back.
// ----------------------------------------------------------------------------
module tmg_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmg_pkg::point_item_t wr_item,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    output tmg_pkg::point_item_t rd_item,
    output logic                 rd_valid,
    input  logic                 rd_ready
);
    import tmg_pkg::*;

    point_item_t        mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               push;
    logic               pop;

    assign wr_ready = count_reg != (FIFO_AW+1)'(FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ===== hdl/tmg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_back
// Position and normal arithmetic, then emits the vertex record and, for
// interior points, the triangle pair through the output register.
// ----------------------------------------------------------------------------
module tmg_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmg_pkg::point_item_t item,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  tmg_pkg::cfg_state_t  cfg_state,
    tmg_mesh_if.source           mesh
);
    import tmg_pkg::*;

    localparam logic [1:0] PH_VERTEX = 2'd0;
    localparam logic [1:0] PH_TRI_A  = 2'd1;
    localparam logic [1:0] PH_TRI_B  = 2'd2;

    logic               b1v_reg;
    point_item_t        it1_reg;
    logic signed [31:0] w1_reg;
    logic signed [31:0] z1_reg;
    logic signed [31:0] nx1_reg;
    logic signed [31:0] ny1_reg;

    logic               b2v_reg;
    point_item_t        it2_reg;
    logic signed [31:0] x2_reg;
    logic signed [31:0] y2_reg;
    logic signed [31:0] z2_reg;
    logic signed [31:0] nx2_reg;
    logic signed [31:0] ny2_reg;

    logic               ev_reg;
    logic [1:0]         phase_reg;
    point_item_t        ite_reg;
    logic signed [31:0] xe_reg;
    logic signed [31:0] ye_reg;
    logic signed [31:0] ze_reg;
    logic signed [31:0] nxe_reg;
    logic signed [31:0] nye_reg;

    logic               ov_reg;
    logic               tri_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic [17:0]        u_reg;
    logic [16:0]        v_reg;
    logic signed [17:0] nx_reg;
    logic signed [17:0] ny_reg;
    logic signed [17:0] nz_reg;
    logic               last_reg;

    logic               rdy_o;
    logic               take_o;
    logic [1:0]         last_phase;
    logic               e_free;
    logic               rdy_b2;
    logic               rdy_b1;

    logic               r_tri;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic [17:0]        r_u;
    logic [16:0]        r_v;
    logic signed [17:0] r_nx;
    logic signed [17:0] r_ny;
    logic signed [17:0] r_nz;
    logic               r_last;
    logic [15:0]        idx_b1;
    logic [15:0]        idx_bn1;
    logic [15:0]        idx_bn2;

    logic signed [31:0] outer_s;

    assign outer_s    = $signed({8'd0, cfg_state.outer});
    assign rdy_o      = !ov_reg || mesh.ready;
    assign take_o     = ev_reg && rdy_o;
    assign last_phase = ite_reg.tris ? PH_TRI_B : PH_VERTEX;
    assign e_free     = !ev_reg || (take_o && phase_reg == last_phase);
    assign rdy_b2     = !b2v_reg || e_free;
    assign rdy_b1     = !b1v_reg || rdy_b2;
    assign item_ready = rdy_b1;

    always_comb
    begin
        idx_b1  = ite_reg.base + 16'd1;
        idx_bn1 = ite_reg.base + {8'd0, ite_reg.n} + 16'd1;
        idx_bn2 = ite_reg.base + {8'd0, ite_reg.n} + 16'd2;
        r_tri   = 1'b1;
        r_u     = '0;
        r_v     = '0;
        r_nx    = '0;
        r_ny    = '0;
        r_nz    = '0;
        case (phase_reg)
            PH_TRI_A:
            begin
                r_x    = $signed({16'd0, ite_reg.base});
                r_y    = $signed({16'd0, idx_bn1});
                r_z    = $signed({16'd0, idx_b1});
                r_last = 1'b0;
            end
            PH_TRI_B:
            begin
                r_x    = $signed({16'd0, idx_b1});
                r_y    = $signed({16'd0, idx_bn1});
                r_z    = $signed({16'd0, idx_bn2});
                r_last = 1'b1;
            end
            default:
            begin
                r_tri  = 1'b0;
                r_x    = xe_reg;
                r_y    = ye_reg;
                r_z    = ze_reg;
                r_u    = ite_reg.tex_u;
                r_v    = ite_reg.tex_v;
                r_nx   = nxe_reg[17:0];
                r_ny   = nye_reg[17:0];
                r_nz   = ite_reg.sin_p;
                r_last = !ite_reg.tris;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1v_reg   <= 1'b0;
            b2v_reg   <= 1'b0;
            ev_reg    <= 1'b0;
            phase_reg <= PH_VERTEX;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (rdy_b1)
                b1v_reg <= item_valid;
            if (rdy_b2)
                b2v_reg <= b1v_reg;
            if (take_o && phase_reg != last_phase)
                phase_reg <= phase_reg + 2'd1;
            if (e_free)
            begin
                ev_reg    <= b2v_reg;
                phase_reg <= PH_VERTEX;
            end
            if (rdy_o)
                ov_reg <= ev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b1)
        begin
            it1_reg <= item;
            w1_reg  <= $signed({8'd0, cfg_state.inner}) + mul_round(outer_s, 32'(item.cos_p));
            z1_reg  <= mul_round(outer_s, 32'(item.sin_p));
            nx1_reg <= mul_round(32'(item.cos_t), 32'(item.cos_p));
            ny1_reg <= mul_round(32'(item.sin_t), 32'(item.cos_p));
        end
        if (rdy_b2)
        begin
            it2_reg <= it1_reg;
            x2_reg  <= mul_round(w1_reg, 32'(it1_reg.cos_t));
            y2_reg  <= mul_round(w1_reg, 32'(it1_reg.sin_t));
            z2_reg  <= z1_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
        end
        if (e_free)
        begin
            ite_reg <= it2_reg;
            xe_reg  <= x2_reg;
            ye_reg  <= y2_reg;
            ze_reg  <= z2_reg;
            nxe_reg <= nx2_reg;
            nye_reg <= ny2_reg;
        end
        if (rdy_o)
        begin
            tri_reg  <= r_tri;
            cx_reg   <= r_x;
            cy_reg   <= r_y;
            cz_reg   <= r_z;
            u_reg    <= r_u;
            v_reg    <= r_v;
            nx_reg   <= r_nx;
            ny_reg   <= r_ny;
            nz_reg   <= r_nz;
            last_reg <= r_last;
        end
    end

    assign mesh.valid       = ov_reg;
    assign mesh.is_triangle = tri_reg;
    assign mesh.coord_x     = cx_reg;
    assign mesh.coord_y     = cy_reg;
    assign mesh.coord_z     = cz_reg;
    assign mesh.tex_u       = u_reg;
    assign mesh.tex_v       = v_reg;
    assign mesh.normal_x    = nx_reg;
    assign mesh.normal_y    = ny_reg;
    assign mesh.normal_z    = nz_reg;
    assign mesh.last        = last_reg;

endmodule

// ===== hdl/torus_mesh_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_mesh_generator
// Streams vertex and triangle records of an N-by-N torus tessellation.
//
// grid: one transaction per grid point (ring_index, col_index).
// mesh: one vertex record per point, then two triangle records when both
//       indices are below N; last marks the final record of a point.
// cfg:  register writes (0 inner_radius, 1 outer_radius, 2 tess_count),
//       always ready; other indices are ignored.
// Throughput is one point per cycle for boundary points and one record per
// cycle overall while the mesh receiver is ready and no reciprocal rebuild
// is under way, so an interior point occupies the mesh channel for its three
// records; the output record rate is set by the emit stage in the back end.
// After a tess_count write the reciprocal of N is rebuilt bit-serially and
// grid.ready stays low until the rebuild ends. Reset loads the default registers
// and the matching reciprocal, so no wait follows reset.
// A stalled mesh receiver fills the back pipeline, then the 4-entry queue,
// then the front pipeline, after which grid.ready drops.
// ----------------------------------------------------------------------------
module torus_mesh_generator (
    input  logic        clk,
    input  logic        rst_n,
    tmg_grid_if.sink    grid,
    tmg_mesh_if.source  mesh,
    tmg_cfg_if.sink     cfg
);
    import tmg_pkg::*;

    cfg_state_t  cfg_state;
    point_item_t front_item;
    logic        front_valid;
    logic        front_ready;
    point_item_t back_item;
    logic        back_valid;
    logic        back_ready;

    tmg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    tmg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .grid       (grid),
        .cfg_state  (cfg_state),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    tmg_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (back_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    tmg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .cfg_state  (cfg_state),
        .mesh       (mesh)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the torus mesh generator: directed grid points, then
// random points under several idling phases and register settings; every
// mesh record is compared against an in-bench vertex and triangle predictor.
// ----------------------------------------------------------------------------
module tb;
    import tmg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TABLE_SIZE     = 1024;

    typedef struct packed {
        logic               is_triangle;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [17:0]        tex_u;
        logic [16:0]        tex_v;
        logic signed [17:0] normal_x;
        logic signed [17:0] normal_y;
        logic signed [17:0] normal_z;
        logic               last;
    } mesh_rec_t;

    typedef struct {
        logic [7:0] ring;
        logic [7:0] col;
        logic       typed;
        mesh_rec_t  rec;
    } grid_row_t;

    logic clk;
    logic rst_n;

    tmg_grid_if grid ();
    tmg_mesh_if mesh ();
    tmg_cfg_if  cfg ();

    torus_mesh_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .grid  (grid),
        .mesh  (mesh),
        .cfg   (cfg)
    );

    mesh_rec_t expected_recs[$];
    longint    sine_q[TABLE_SIZE];
    longint    cosine_q[TABLE_SIZE];
    logic [23:0] inner_r;
    logic [23:0] outer_r;
    logic [7:0]  tess_n;
    int          mismatches;
    int          idle_pct;
    int          stall_pct;
    int          hold_cycles;
    bit          timed_out;
    int          quiet_cycles;
    grid_row_t   directed[$];

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint poly_sin(logic [31:0] f);
        logic [1:0]  quad;
        logic [63:0] q;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] s;
        quad = f[31:30];
        q = 64'(f[29:0]);
        z = quad[0] ? (64'd1073741824 - q) : q;
        z2 = (z * z) >> 30;
        t = 64'd4858527;
        t = 64'd85569306 - ((z2 * t) >> 30);
        t = 64'd693598668 - ((z2 * t) >> 30);
        t = 64'd1686629713 - ((z2 * t) >> 30);
        s = (z * t) >> 30;
        s = (s + (64'd1 << 13)) >> 14;
        if (s > 64'd65536)
            s = 64'd65536;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint round_mul(longint a, longint b);
        bit     neg;
        longint ma;
        longint mb;
        longint m;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = (ma * mb + 32768) >>> 16;
        return neg ? -m : m;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic predict_point(logic [7:0] ring, logic [7:0] col);
        longint    n;
        int        kt;
        int        kp;
        longint    w;
        longint    base;
        mesh_rec_t r;
        bit        tris;
        n = tess_n == 0 ? 1 : tess_n;
        tris = ring < n && col < n;
        kt = int'(((longint'(ring) * TABLE_SIZE + n / 2) / n) % TABLE_SIZE);
        kp = int'(((longint'(col) * TABLE_SIZE + n / 2) / n) % TABLE_SIZE);
        w = longint'(inner_r) + round_mul(outer_r, cosine_q[kp]);
        r = '0;
        r.coord_x = 32'(clip(round_mul(w, cosine_q[kt]), -64'sd2147483648, 64'sd2147483647));
        r.coord_y = 32'(clip(round_mul(w, sine_q[kt]), -64'sd2147483648, 64'sd2147483647));
        r.coord_z = 32'(clip(round_mul(outer_r, sine_q[kp]), -64'sd2147483648,
                             64'sd2147483647));
        r.tex_u = 18'(clip(((longint'(ring) << 17) + n / 2) / n, 0, 262143));
        r.tex_v = 17'(clip(((longint'(col) << 16) + n / 2) / n, 0, 131071));
        r.normal_x = 18'(clip(round_mul(cosine_q[kt], cosine_q[kp]), -131072, 131071));
        r.normal_y = 18'(clip(round_mul(sine_q[kt], cosine_q[kp]), -131072, 131071));
        r.normal_z = 18'(clip(sine_q[kp], -131072, 131071));
        r.last = !tris;
        expected_recs.push_back(r);
        if (tris)
        begin
            base = longint'(ring) * (n + 1) + col;
            r = '0;
            r.is_triangle = 1'b1;
            r.coord_x = 32'(base & 16'hFFFF);
            r.coord_y = 32'((base + n + 1) & 16'hFFFF);
            r.coord_z = 32'((base + 1) & 16'hFFFF);
            expected_recs.push_back(r);
            r.coord_x = 32'((base + 1) & 16'hFFFF);
            r.coord_z = 32'((base + n + 2) & 16'hFFFF);
            r.last = 1'b1;
            expected_recs.push_back(r);
        end
    endtask

    // output side: random stall and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mesh.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            mesh.ready <= 1'b0;
        end
        else
            mesh.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && mesh.valid && mesh.ready)
        begin
            if (expected_recs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected mesh record %p", mesh_rec_t'({mesh.is_triangle,
                             mesh.coord_x, mesh.coord_y, mesh.coord_z, mesh.tex_u,
                             mesh.tex_v, mesh.normal_x, mesh.normal_y, mesh.normal_z,
                             mesh.last}));
            end
            else
            begin
                mesh_rec_t e;
                mesh_rec_t a;
                e = expected_recs.pop_front();
                a = {mesh.is_triangle, mesh.coord_x, mesh.coord_y, mesh.coord_z,
                     mesh.tex_u, mesh.tex_v, mesh.normal_x, mesh.normal_y,
                     mesh.normal_z, mesh.last};
                if (a !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mesh mismatch: expected %p actual %p", e, a);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((grid.valid && grid.ready) || (mesh.valid && mesh.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays high after a transaction; idling or draining drops it
    task automatic send_point(logic [7:0] ring, logic [7:0] col);
        while ($urandom_range(99) < idle_pct)
        begin
            grid.valid <= 1'b0;
            @(posedge clk);
        end
        grid.valid      <= 1'b1;
        grid.ring_index <= ring;
        grid.col_index  <= col;
        do
            @(posedge clk);
        while (!grid.ready);
        predict_point(ring, col);
    endtask

    task automatic wait_drained();
        grid.valid <= 1'b0;
        while (expected_recs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_INNER)
            inner_r = value;
        else if (idx == REG_OUTER)
            outer_r = value;
        else if (idx == REG_TESS)
            tess_n = value[7:0];
        @(posedge clk);
    endtask

    task automatic add_row(logic [7:0] ring, logic [7:0] col, bit typed, mesh_rec_t rec);
        grid_row_t row;
        row.ring = ring;
        row.col = col;
        row.typed = typed;
        row.rec = rec;
        directed.push_back(row);
    endtask

    task automatic random_points(int count);
        logic [7:0] ring;
        logic [7:0] col;
        int         n;
        for (int i = 0; i < count; i++)
        begin
            n = tess_n == 0 ? 1 : tess_n;
            if ($urandom_range(9) < 8)
            begin
                ring = 8'($urandom_range(n));
                col  = 8'($urandom_range(n));
            end
            else
            begin
                ring = 8'($urandom);
                col  = 8'($urandom);
            end
            send_point(ring, col);
        end
    endtask

    initial
    begin
        mesh_rec_t r;
        for (int k = 0; k < TABLE_SIZE; k++)
        begin
            sine_q[k]   = poly_sin(32'((64'(k) << 32) / TABLE_SIZE));
            cosine_q[k] = poly_sin(32'((64'(k) << 32) / TABLE_SIZE) + 32'h40000000);
        end
        inner_r = INNER_RESET;
        outer_r = OUTER_RESET;
        tess_n  = TESS_RESET;
        mismatches = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        grid.valid = 1'b0;
        grid.ring_index = '0;
        grid.col_index = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // origin after reset: position (1.25, 0, 0), normal (1, 0, 0)
        r = '0;
        r.coord_x = 32'sd81920;
        r.normal_x = 18'sd65536;
        add_row(8'd0, 8'd0, 1'b1, r);
        r = '0;
        r.is_triangle = 1'b1;
        r.coord_y = 32'sd17;
        r.coord_z = 32'sd1;
        add_row(8'd0, 8'd0, 1'b1, r);
        r.coord_x = 32'sd1;
        r.coord_z = 32'sd18;
        r.last = 1'b1;
        add_row(8'd0, 8'd0, 1'b1, r);
        add_row(8'd4, 8'd0, 1'b0, r);
        add_row(8'd0, 8'd4, 1'b0, r);
        add_row(8'd8, 8'd12, 1'b0, r);
        add_row(8'd15, 8'd15, 1'b0, r);
        add_row(8'd16, 8'd16, 1'b0, r);
        add_row(8'd16, 8'd3, 1'b0, r);
        add_row(8'd255, 8'd255, 1'b0, r);
        add_row(8'd170, 8'd85, 1'b0, r);
        add_row(8'd85, 8'd170, 1'b0, r);

        for (int i = 0; i < directed.size(); i++)
        begin
            if (directed[i].typed)
            begin
                // first entry covers all three records of the origin point
                if (i == 0)
                begin
                    send_point(directed[0].ring, directed[0].col);
                    expected_recs.delete();
                    for (int j = 0; j < 3; j++)
                        expected_recs.push_back(directed[j].rec);
                end
            end
            else
                send_point(directed[i].ring, directed[i].col);
        end
        wait_drained();

        // extremes of the registers
        write_reg(REG_INNER, 24'hFFFFFF);
        write_reg(REG_OUTER, 24'hFFFFFF);
        write_reg(REG_TESS, 24'd255);
        write_reg(2'd3, 24'h5A5A5A);
        send_point(8'd0, 8'd0);
        send_point(8'd254, 8'd254);
        send_point(8'd255, 8'd0);
        send_point(8'd64, 8'd191);
        wait_drained();
        write_reg(REG_INNER, 24'd0);
        write_reg(REG_OUTER, 24'd0);
        write_reg(REG_TESS, 24'd0);
        send_point(8'd0, 8'd0);
        send_point(8'd1, 8'd0);
        send_point(8'd0, 8'd1);
        send_point(8'd255, 8'd128);
        wait_drained();
        write_reg(REG_TESS, 24'd1);
        send_point(8'd0, 8'd0);
        send_point(8'd1, 8'd1);
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_INNER, 24'($urandom));
            write_reg(REG_OUTER, 24'($urandom_range(24'h40000)));
            write_reg(REG_TESS, 24'($urandom_range(1, 24)));
            idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 85 : 33) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 85 : 33) : 0;
            random_points(85);
            if (ph == 0)
            begin
                hold_cycles = 200;
                random_points(20);
            end
            wait_drained();
        end
        idle_pct = 0;
        stall_pct = 20;
        write_reg(REG_INNER, 24'hFFFFFF);
        write_reg(REG_OUTER, 24'h800000);
        write_reg(REG_TESS, 24'd255);
        random_points(40);
        wait_drained();

        if (mismatches == 0 && expected_recs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/tmg_pkg.sv
hdl/tmg_if.sv
hdl/tmg_cfg.sv
hdl/tmg_front.sv
hdl/tmg_fifo.sv
hdl/tmg_back.sv
hdl/torus_mesh_generator.sv
tb/sv/tb.sv
